// ===== hw/rtl/euler_to_quaternion_defines.svh =====
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Generic clocked assertion, disabled while reset is asserted.
`define E2Q_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A valid component lies within plus or minus the given limit.
`define E2Q_ASSERT_RANGE(lbl, vld, val, lim) \
    `E2Q_ASSERT(lbl, (vld) |-> (((val) <= (lim)) && ((val) >= -(lim))), "component out of range")

`endif

// ===== hw/rtl/e2q_pkg.sv =====
// Package with the types and constants of the Euler angle to quaternion converter.
package e2q_pkg;

    localparam int CORDIC_STEPS = 31;
    localparam int SC_W = 32;
    localparam int CW = 34;
    localparam int ZW = 42;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    localparam logic signed [ZW-1:0] ATAN_TURN_Q32 [0:CORDIC_STEPS-1] = '{
        42'sd536870912, 42'sd316933406, 42'sd167458907, 42'sd85004756,
        42'sd42667331, 42'sd21354465, 42'sd10679838, 42'sd5340245,
        42'sd2670163, 42'sd1335087, 42'sd667544, 42'sd333772, 42'sd166886,
        42'sd83443, 42'sd41722, 42'sd20861, 42'sd10430, 42'sd5215, 42'sd2608,
        42'sd1304, 42'sd652, 42'sd326, 42'sd163, 42'sd81, 42'sd41, 42'sd20,
        42'sd10, 42'sd5, 42'sd3, 42'sd1, 42'sd1
    };

    typedef struct packed {
        logic signed [SC_W-1:0] c;
        logic signed [SC_W-1:0] s;
    } sincos_t;

endpackage

// ===== hw/rtl/e2q_sincos.sv =====
// Pipelined rotation CORDIC giving the cosine and sine of half a binary angle.
module e2q_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                         clk,
    input  logic                         ce,
    input  logic signed [ANGLE_BITS-1:0] angle,
    output e2q_pkg::sincos_t             sc
);

    localparam int STEPS = e2q_pkg::CORDIC_STEPS;
    localparam int CW = e2q_pkg::CW;
    localparam int ZW = e2q_pkg::ZW;
    localparam int SC_W = e2q_pkg::SC_W;

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [ZW-1:0] z_reg [0:STEPS];
    logic signed [ZW-1:0] z_next;

    assign z_next = {{(ZW-ANGLE_BITS){angle[ANGLE_BITS-1]}}, angle} <<< (39 - ANGLE_BITS);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg[0] <= e2q_pkg::CORDIC_GAIN_Q30;
            y_reg[0] <= '0;
            z_reg[0] <= z_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                if (!z_reg[i][ZW-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - (e2q_pkg::ATAN_TURN_Q32[i] <<< 8);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + (e2q_pkg::ATAN_TURN_Q32[i] <<< 8);
                end
            end
        end
    end

    assign sc.c = x_reg[STEPS][SC_W-1:0];
    assign sc.s = y_reg[STEPS][SC_W-1:0];

endmodule

// ===== hw/rtl/e2q_quat_mult.sv =====
// Four-stage product and sum pipeline that forms the quaternion from half-angle sines and cosines.
module e2q_quat_mult #(
    parameter int FRAC_BITS = 14
) (
    input  logic                        clk,
    input  logic                        ce,
    input  e2q_pkg::sincos_t            sc1,
    input  e2q_pkg::sincos_t            sc2,
    input  e2q_pkg::sincos_t            sc3,
    output logic signed [FRAC_BITS+1:0] quat_w,
    output logic signed [FRAC_BITS+1:0] quat_x,
    output logic signed [FRAC_BITS+1:0] quat_y,
    output logic signed [FRAC_BITS+1:0] quat_z
);

    localparam int SC_W = e2q_pkg::SC_W;
    localparam int PW = 2 * SC_W;
    localparam int SW = PW + 2;
    localparam int OW = FRAC_BITS + 2;
    localparam int SH = 60 - FRAC_BITS;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SH - 1);
    localparam logic signed [SW-1:0] LIM = SW'(1) <<< FRAC_BITS;
    localparam logic signed [PW-1:0] RND30 = PW'(1) <<< 29;

    logic signed [PW-1:0]   c1c2_reg, s1s2_reg, c1s2_reg, s1c2_reg;
    logic signed [SC_W-1:0] c1c2r_reg, s1s2r_reg, c1s2r_reg, s1c2r_reg;
    logic signed [SC_W-1:0] c3a_reg, s3a_reg, c3b_reg, s3b_reg;
    logic signed [PW-1:0]   pw0_reg, pw1_reg, px0_reg, px1_reg;
    logic signed [PW-1:0]   py0_reg, py1_reg, pz0_reg, pz1_reg;
    logic signed [PW-1:0]   c1c2_next, s1s2_next, c1s2_next, s1c2_next;

    function automatic logic signed [OW-1:0] to_out(input logic signed [PW-1:0] a,
                                                    input logic signed [PW-1:0] b,
                                                    input logic sub);
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] v;
        sum = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
        v = (sum + HALF) >>> SH;
        if (v > LIM)
        begin
            v = LIM;
        end
        else if (v < -LIM)
        begin
            v = -LIM;
        end
        return v[OW-1:0];
    endfunction

    assign c1c2_next = c1c2_reg + RND30;
    assign s1s2_next = s1s2_reg + RND30;
    assign c1s2_next = c1s2_reg + RND30;
    assign s1c2_next = s1c2_reg + RND30;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            c1c2_reg <= PW'(sc1.c) * PW'(sc2.c);
            s1s2_reg <= PW'(sc1.s) * PW'(sc2.s);
            c1s2_reg <= PW'(sc1.c) * PW'(sc2.s);
            s1c2_reg <= PW'(sc1.s) * PW'(sc2.c);
            c3a_reg <= sc3.c;
            s3a_reg <= sc3.s;

            c1c2r_reg <= c1c2_next[SC_W+29:30];
            s1s2r_reg <= s1s2_next[SC_W+29:30];
            c1s2r_reg <= c1s2_next[SC_W+29:30];
            s1c2r_reg <= s1c2_next[SC_W+29:30];
            c3b_reg <= c3a_reg;
            s3b_reg <= s3a_reg;

            pw0_reg <= PW'(c1c2r_reg) * PW'(c3b_reg);
            pw1_reg <= PW'(s1s2r_reg) * PW'(s3b_reg);
            px0_reg <= PW'(c1s2r_reg) * PW'(c3b_reg);
            px1_reg <= PW'(s1c2r_reg) * PW'(s3b_reg);
            py0_reg <= PW'(s1c2r_reg) * PW'(c3b_reg);
            py1_reg <= PW'(c1s2r_reg) * PW'(s3b_reg);
            pz0_reg <= PW'(c1c2r_reg) * PW'(s3b_reg);
            pz1_reg <= PW'(s1s2r_reg) * PW'(c3b_reg);

            quat_w <= to_out(pw0_reg, pw1_reg, 1'b0);
            quat_x <= to_out(px0_reg, px1_reg, 1'b0);
            quat_y <= to_out(py0_reg, py1_reg, 1'b1);
            quat_z <= to_out(pz0_reg, pz1_reg, 1'b1);
        end
    end

endmodule

// ===== hw/rtl/euler_to_quaternion.sv =====
// Top level of the Euler angle to quaternion converter.
// One beat is accepted every cycle while no output beat is stalled; the 32-stage CORDIC
// (input register plus 31 rotations) and the 4-stage product pipeline advance together.
// When the output beat is stalled the whole pipeline holds and the input is stalled.
// Reset clears all valid bits asynchronously; data registers are not reset.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [ANGLE_BITS-1:0] yaw,
    input  logic signed [ANGLE_BITS-1:0] pitch,
    input  logic signed [ANGLE_BITS-1:0] roll,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [FRAC_BITS+1:0]  quat_w,
    output logic signed [FRAC_BITS+1:0]  quat_x,
    output logic signed [FRAC_BITS+1:0]  quat_y,
    output logic signed [FRAC_BITS+1:0]  quat_z
);

    localparam int LAT = e2q_pkg::CORDIC_STEPS + 5;
    localparam logic signed [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) <<< FRAC_BITS;

    logic             ce;
    logic [LAT-1:0]   valid_reg;
    e2q_pkg::sincos_t sc_yaw, sc_pitch, sc_roll;

    assign ce = !valid_reg[LAT-1] || !out_stall;
    assign in_stall = !ce;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ce)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_yaw (
        .clk(clk), .ce(ce), .angle(yaw), .sc(sc_yaw)
    );

    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_pitch (
        .clk(clk), .ce(ce), .angle(pitch), .sc(sc_pitch)
    );

    e2q_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos_roll (
        .clk(clk), .ce(ce), .angle(roll), .sc(sc_roll)
    );

    e2q_quat_mult #(.FRAC_BITS(FRAC_BITS)) u_quat_mult (
        .clk(clk), .ce(ce),
        .sc1(sc_yaw), .sc2(sc_pitch), .sc3(sc_roll),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
    );

    `E2Q_ASSERT(a_stall_only_when_full, in_stall |-> out_valid, "input stalled with no output beat")
    `E2Q_ASSERT_RANGE(a_w_range, out_valid, quat_w, ONE)
    `E2Q_ASSERT_RANGE(a_z_range, out_valid, quat_z, ONE)

endmodule
